/* hw/rtl/tdp_pkg.sv */
package tdp_pkg;

  localparam int CANDIDATE_WIDTH     = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int OUT_DATA_WIDTH      = 8;

endpackage

/* hw/rtl/trial_division_primality.sv */
// Channel   Direction  Word                               Notes
// s_axis    in         tdata[31:0] = candidate            taken only while no test is running
// m_axis    out        tdata[0] = is_prime, [7:1] zero    held in a register until taken
//
// Zero, one, two and even values are settled in the classify state, without any division.
// Each odd divisor goes one bit a cycle through the restoring divider; a check state then
// compares the quotient with the divisor and tests the remainder for zero.
// The reset rst is synchronous and clears the state and the output valid.
// A stalled output holds its word; the next word may be taken and tested meanwhile,
// and its finished test waits until the held word moves on.
module trial_division_primality #(
  parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [tdp_pkg::CANDIDATE_WIDTH-1:0]  s_axis_tdata,   // [31:0] candidate
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [tdp_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata    // [0] is_prime, [7:1] zero
);
  import tdp_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CLASSIFY = 3'd1;
  localparam logic [2:0] ST_DIV      = 3'd2;
  localparam logic [2:0] ST_CHECK    = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  localparam logic [W-1:0] VAL_TWO   = W'(2);
  localparam logic [W-1:0] VAL_THREE = W'(3);

  logic [2:0]       state;
  logic [W-1:0]     value;
  logic [W-1:0]     divisor;
  logic [W-1:0]     rem;
  logic [W-1:0]     quot;
  logic [CNT_W-1:0] cnt;
  logic             result;
  logic             out_valid;
  logic             out_result;

  logic [W-1:0]     cand_value;
  logic [W:0]       rem_shift;
  logic [W:0]       diff;
  logic             take;
  logic             out_free;
  logic             in_accept;

  generate
    if (W > CANDIDATE_WIDTH) begin : g_wide
      assign cand_value = {{(W - CANDIDATE_WIDTH){1'b0}}, s_axis_tdata};
    end else if (W == CANDIDATE_WIDTH) begin : g_equal
      assign cand_value = s_axis_tdata;
    end else begin : g_narrow
      assign cand_value = s_axis_tdata[W-1:0];
    end
  endgenerate

  assign rem_shift = {rem, quot[W-1]};
  assign diff      = rem_shift - {1'b0, divisor};
  assign take      = !diff[W];
  assign out_free  = !out_valid || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_WIDTH - 1){1'b0}}, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          if (value < VAL_TWO || value == VAL_TWO || !value[0]) begin
            state <= ST_FIN;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_W'(W - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (quot < divisor || rem == '0) begin
            state <= ST_FIN;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          value   <= cand_value;
          divisor <= VAL_THREE;
        end
      end
      ST_CLASSIFY: begin
        result <= (value == VAL_TWO);
        rem    <= '0;
        quot   <= value;
        cnt    <= '0;
      end
      ST_DIV: begin
        rem  <= take ? diff[W-1:0] : rem_shift[W-1:0];
        quot <= {quot[W-2:0], take};
        cnt  <= cnt + 1'b1;
      end
      ST_CHECK: begin
        result  <= (quot < divisor);
        divisor <= divisor + VAL_TWO;
        rem     <= '0;
        quot    <= value;
        cnt     <= '0;
      end
      ST_FIN: begin
        if (out_free) begin
          out_result <= result;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/tdp_checker.sv */
module tdp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [tdp_pkg::CANDIDATE_WIDTH-1:0]  s_axis_tdata,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [tdp_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata
);
  import tdp_pkg::*;

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // Only the lowest bit of a result word carries data.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_WIDTH-1:1] == '0)
    else $error("padding bits of result word not zero");

  // Once a word is taken, the test runs before another word is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a test is running");

  // Reset leaves no result word pending.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word valid after reset");

endmodule

bind trial_division_primality tdp_checker u_tdp_checker (.*);
